// File: rtl/core/assert_macros.svh
// Assertion macros shared by the receiver RTL; each samples clk and is disabled in rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked at every rising edge outside reset.
`define HAFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication.
`define HAFR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define HAFR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/hafr_pkg.sv
// Shared types, codes and defaults of the HDLC asynchronous frame receiver.
package hafr_pkg;

  localparam int BUF_DEPTH_DEF   = 64;
  localparam int COUNT_WIDTH_DEF = 32;
  localparam int NUM_CNT         = 8;
  localparam int CNT_AW          = 3;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_WAIT = 2'd1,
    PH_DATA = 2'd2,
    PH_ESC  = 2'd3
  } phase_t;

  // Request function codes.
  localparam logic [1:0] FUNC_CHAR = 2'd0;
  localparam logic [1:0] FUNC_ARM  = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;

  // Result event codes.
  localparam logic [3:0] EV_NONE     = 4'd0;
  localparam logic [3:0] EV_DONE     = 4'd1;
  localparam logic [3:0] EV_STORED   = 4'd2;
  localparam logic [3:0] EV_PARITY   = 4'd3;
  localparam logic [3:0] EV_FRAMING  = 4'd4;
  localparam logic [3:0] EV_NOISE    = 4'd5;
  localparam logic [3:0] EV_OVERRUN  = 4'd6;
  localparam logic [3:0] EV_NO_FLAG  = 4'd7;
  localparam logic [3:0] EV_EMPTY    = 4'd8;
  localparam logic [3:0] EV_OVERFLOW = 4'd9;
  localparam logic [3:0] EV_BAD_ESC  = 4'd10;
  localparam logic [3:0] EV_MASK     = 4'hF;

  // Statistics counter indexes.
  localparam logic [CNT_AW-1:0] CNT_PARITY   = 3'd0;
  localparam logic [CNT_AW-1:0] CNT_FRAMING  = 3'd1;
  localparam logic [CNT_AW-1:0] CNT_NOISE    = 3'd2;
  localparam logic [CNT_AW-1:0] CNT_OVERRUN  = 3'd3;
  localparam logic [CNT_AW-1:0] CNT_NO_FLAG  = 3'd4;
  localparam logic [CNT_AW-1:0] CNT_EMPTY    = 3'd5;
  localparam logic [CNT_AW-1:0] CNT_OVERFLOW = 3'd6;
  localparam logic [CNT_AW-1:0] CNT_BAD_ESC  = 3'd7;

  // Configuration register indexes and reset values.
  localparam logic [1:0] CFG_FLAG  = 2'd0;
  localparam logic [1:0] CFG_ESC   = 2'd1;
  localparam logic [1:0] CFG_MASK  = 2'd2;
  localparam logic [1:0] CFG_LIMIT = 2'd3;

  localparam logic [7:0] FLAG_RST  = 8'd126;
  localparam logic [7:0] ESC_RST   = 8'd125;
  localparam logic [7:0] MASK_RST  = 8'd32;
  localparam logic [6:0] LIMIT_RST = 7'd64;

endpackage

// File: rtl/core/hafr_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module hafr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [$clog2(DEPTH)-1:0]         wr_addr,
  input  logic [WIDTH-1:0]                 wr_data,
  input  logic                             rd_en,
  input  logic [$clog2(DEPTH)-1:0]         rd_addr,
  output logic [WIDTH-1:0]                 rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/hdlc_async_frame_receiver.sv
// A request's result is in the output register in the cycle after it is accepted.
// Throughput: one request per cycle while each result is taken; the result register frees in the cycle it is taken.
// Counter bumps are read from the counter RAM at accept and written back in the cycle after,
// with a forwarding path covering a request that reads the counter being written.
// Reset clears phase, parity latch, byte count and the eight counter valid bits and loads
// the configuration defaults; the payload RAM is not cleared and needs no sweep.
module hdlc_async_frame_receiver #(
  parameter int BUF_DEPTH   = hafr_pkg::BUF_DEPTH_DEF,
  parameter int COUNT_WIDTH = hafr_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,

  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic        char_valid,
  input  logic [7:0]  rx_char,
  input  logic        parity_err,
  input  logic        framing_err,
  input  logic        noise_err,
  input  logic        overrun_err,
  input  logic        read_counter,
  input  logic [5:0]  read_index,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  event_code,
  output logic [6:0]  frame_length,
  output logic        receiving,
  output logic [31:0] read_data
);

  localparam int AW = $clog2(BUF_DEPTH);
  localparam int CW = $clog2(BUF_DEPTH + 1);

  // Configuration registers.
  logic [7:0] flag_byte;
  logic [7:0] escape_byte;
  logic [7:0] escape_xor_mask;
  logic [6:0] payload_limit;

  // Receive control state.
  hafr_pkg::phase_t phase, phase_next;
  logic             parity_latch, parity_latch_next;
  logic [CW-1:0]    count, count_next;

  // Result stage.
  logic [3:0]             s1_ev;
  logic                   s1_rd;
  logic                   s1_rd_cnt;
  logic                   s1_pay_ok;
  logic                   s1_cnt_ok;
  logic                   s1_cnt_vld;

  // Counter write-back and forwarding.
  logic                   wb_pend;
  logic [hafr_pkg::CNT_AW-1:0] wb_idx;
  logic                   fwd_hit;
  logic [COUNT_WIDTH-1:0] fwd_val;
  logic [hafr_pkg::NUM_CNT-1:0] cnt_valid;

  logic accept;

  // Decoded character conditions.
  logic       ch_ok;
  logic       pe_eff;
  logic       line_err;
  logic       is_flag;
  logic       is_esc;
  logic       room;
  logic [7:0] unesc;
  logic       unesc_ok;

  // Per-request actions.
  logic [3:0]                  ev;
  logic                        bump;
  logic [hafr_pkg::CNT_AW-1:0] bump_idx;
  logic                        pay_we;
  logic [7:0]                  pay_wdata;

  // Memory ports.
  logic [AW-1:0]               pay_raddr;
  logic [7:0]                  pay_rdata;
  logic [hafr_pkg::CNT_AW-1:0] cnt_raddr;
  logic [COUNT_WIDTH-1:0]      cnt_rdata;
  logic [COUNT_WIDTH-1:0]      cnt_cur;
  logic [COUNT_WIDTH-1:0]      cnt_wdata;

  assign in_ready = !rst && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      flag_byte       <= hafr_pkg::FLAG_RST;
      escape_byte     <= hafr_pkg::ESC_RST;
      escape_xor_mask <= hafr_pkg::MASK_RST;
      payload_limit   <= hafr_pkg::LIMIT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        hafr_pkg::CFG_FLAG:  flag_byte       <= cfg_data;
        hafr_pkg::CFG_ESC:   escape_byte     <= cfg_data;
        hafr_pkg::CFG_MASK:  escape_xor_mask <= cfg_data;
        hafr_pkg::CFG_LIMIT: payload_limit   <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ch_ok    = char_valid && (phase != hafr_pkg::PH_IDLE);
    pe_eff   = parity_err || parity_latch;
    line_err = pe_eff || framing_err || noise_err || overrun_err;
    is_flag  = (rx_char == flag_byte);
    is_esc   = (rx_char == escape_byte);
    room     = (32'(count) < 32'(payload_limit)) && (32'(count) < BUF_DEPTH);
    unesc    = rx_char ^ escape_xor_mask;
    unesc_ok = (unesc == flag_byte) || (unesc == escape_byte);
  end

  // Next receive phase.
  always_comb begin
    phase_next = phase;
    if (accept && func == hafr_pkg::FUNC_ARM) begin
      phase_next = hafr_pkg::PH_WAIT;
    end else if (accept && func == hafr_pkg::FUNC_CHAR && ch_ok) begin
      if (line_err) begin
        phase_next = hafr_pkg::PH_WAIT;
      end else begin
        unique case (phase)
          hafr_pkg::PH_WAIT: begin
            if (is_flag) phase_next = hafr_pkg::PH_DATA;
          end
          hafr_pkg::PH_DATA: begin
            if (is_flag) begin
              if (count != '0) phase_next = hafr_pkg::PH_IDLE;
            end else if (is_esc) begin
              phase_next = hafr_pkg::PH_ESC;
            end else if (!room) begin
              phase_next = hafr_pkg::PH_WAIT;
            end
          end
          hafr_pkg::PH_ESC: begin
            phase_next = (room && unesc_ok) ? hafr_pkg::PH_DATA : hafr_pkg::PH_WAIT;
          end
          default: ;
        endcase
      end
    end
  end

  // Event, counter bump, payload write, byte count and parity latch.
  always_comb begin
    ev                = hafr_pkg::EV_NONE;
    bump              = 1'b0;
    bump_idx          = hafr_pkg::CNT_PARITY;
    pay_we            = 1'b0;
    pay_wdata         = rx_char;
    count_next        = count;
    parity_latch_next = parity_latch;
    if (accept) begin
      case (func)
        hafr_pkg::FUNC_CHAR: begin
          if (!ch_ok) begin
            parity_latch_next = parity_latch || parity_err;
          end else begin
            // The latched parity error is consumed by this character.
            parity_latch_next = 1'b0;
            bump = 1'b1;
            if (pe_eff) begin
              ev = hafr_pkg::EV_PARITY;   bump_idx = hafr_pkg::CNT_PARITY;
            end else if (framing_err) begin
              ev = hafr_pkg::EV_FRAMING;  bump_idx = hafr_pkg::CNT_FRAMING;
            end else if (noise_err) begin
              ev = hafr_pkg::EV_NOISE;    bump_idx = hafr_pkg::CNT_NOISE;
            end else if (overrun_err) begin
              ev = hafr_pkg::EV_OVERRUN;  bump_idx = hafr_pkg::CNT_OVERRUN;
            end else begin
              bump = 1'b0;
              unique case (phase)
                hafr_pkg::PH_WAIT: begin
                  if (is_flag) begin
                    count_next = '0;
                  end else begin
                    ev = hafr_pkg::EV_NO_FLAG; bump = 1'b1;
                    bump_idx = hafr_pkg::CNT_NO_FLAG;
                  end
                end
                hafr_pkg::PH_DATA: begin
                  if (is_flag) begin
                    if (count != '0) begin
                      ev = hafr_pkg::EV_DONE;
                    end else begin
                      ev = hafr_pkg::EV_EMPTY; bump = 1'b1;
                      bump_idx = hafr_pkg::CNT_EMPTY;
                    end
                  end else if (!is_esc) begin
                    if (room) begin
                      ev = hafr_pkg::EV_STORED; pay_we = 1'b1;
                      count_next = count + CW'(1);
                    end else begin
                      ev = hafr_pkg::EV_OVERFLOW; bump = 1'b1;
                      bump_idx = hafr_pkg::CNT_OVERFLOW;
                    end
                  end
                end
                hafr_pkg::PH_ESC: begin
                  if (!room) begin
                    ev = hafr_pkg::EV_OVERFLOW; bump = 1'b1;
                    bump_idx = hafr_pkg::CNT_OVERFLOW;
                  end else if (unesc_ok) begin
                    ev = hafr_pkg::EV_STORED; pay_we = 1'b1; pay_wdata = unesc;
                    count_next = count + CW'(1);
                  end else begin
                    ev = hafr_pkg::EV_BAD_ESC; bump = 1'b1;
                    bump_idx = hafr_pkg::CNT_BAD_ESC;
                  end
                end
                default: ;
              endcase
            end
          end
        end
        hafr_pkg::FUNC_ARM: parity_latch_next = 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= hafr_pkg::PH_IDLE;
      parity_latch <= 1'b0;
      count        <= '0;
    end else begin
      phase        <= phase_next;
      parity_latch <= parity_latch_next;
      count        <= count_next;
    end
  end

  assign pay_raddr = AW'(read_index);
  assign cnt_raddr = bump ? bump_idx : read_index[hafr_pkg::CNT_AW-1:0];

  hafr_ram #(
    .WIDTH (8),
    .DEPTH (BUF_DEPTH)
  ) u_payload_ram (
    .clk     (clk),
    .wr_en   (pay_we),
    .wr_addr (count[AW-1:0]),
    .wr_data (pay_wdata),
    .rd_en   (accept),
    .rd_addr (pay_raddr),
    .rd_data (pay_rdata)
  );

  hafr_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (hafr_pkg::NUM_CNT)
  ) u_counter_ram (
    .clk     (clk),
    .wr_en   (wb_pend),
    .wr_addr (wb_idx),
    .wr_data (cnt_wdata),
    .rd_en   (accept),
    .rd_addr (cnt_raddr),
    .rd_data (cnt_rdata)
  );

  // A write landing on the same edge as the read is not seen by the RAM read port.
  assign cnt_cur   = fwd_hit ? fwd_val : (s1_cnt_vld ? cnt_rdata : '0);
  assign cnt_wdata = cnt_cur + COUNT_WIDTH'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      wb_pend   <= 1'b0;
      cnt_valid <= '0;
    end else begin
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      wb_pend <= accept && bump;
      if (wb_pend) begin
        cnt_valid[wb_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ev        <= ev & hafr_pkg::EV_MASK;
      frame_length <= 7'(count_next);
      receiving    <= (phase_next != hafr_pkg::PH_IDLE);
      s1_rd        <= (func == hafr_pkg::FUNC_READ);
      s1_rd_cnt    <= read_counter;
      s1_pay_ok    <= (32'(read_index) < BUF_DEPTH);
      s1_cnt_ok    <= (read_index[5:hafr_pkg::CNT_AW] == '0);
      s1_cnt_vld   <= cnt_valid[cnt_raddr];
      wb_idx       <= cnt_raddr;
      fwd_hit      <= wb_pend && (wb_idx == cnt_raddr);
      fwd_val      <= cnt_wdata;
    end
  end

  always_comb begin
    event_code = s1_ev;
    read_data  = '0;
    if (s1_rd) begin
      if (s1_rd_cnt) begin
        if (s1_cnt_ok) read_data = 32'(cnt_cur);
      end else if (s1_pay_ok) begin
        read_data = 32'(pay_rdata);
      end
    end
  end

`include "assert_macros.svh"

  `HAFR_ASSERT_IMP(a_wb_follows_accept, wb_pend, $past(accept), "write-back without request")
  `HAFR_ASSERT(a_count_bound, 32'(count) <= BUF_DEPTH, "byte count beyond buffer depth")
  `HAFR_ASSERT_IMP(a_store_in_range, pay_we, 32'(count) < BUF_DEPTH, "payload write out of range")
  `HAFR_ASSERT_NXT(a_arm_waits, accept && func == hafr_pkg::FUNC_ARM, phase == hafr_pkg::PH_WAIT && !parity_latch, "arm did not restart flag wait")
  `HAFR_ASSERT_IMP(a_done_disarms, out_valid && s1_ev == hafr_pkg::EV_DONE, !receiving, "frame done while still receiving")

endmodule

// File: bench/tb_top.sv
// Self-checking testbench for the HDLC asynchronous frame receiver.
module tb_top;

  localparam logic [1:0] FUNC_NOP = 2'd3;
  localparam int PAYLOAD_DEPTH = hafr_pkg::BUF_DEPTH_DEF;
  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    logic [1:0] func;
    logic       cv;
    logic [7:0] ch;
    logic       pe;
    logic       fe;
    logic       ne;
    logic       oe;
    logic       rc;
    logic [5:0] ri;
  } deframer_in_t;

  typedef struct packed {
    logic [3:0]  ev;
    logic [6:0]  len;
    logic        rcv;
    logic [31:0] data;
  } deframer_out_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  func = '0;
  logic        char_valid = 1'b0;
  logic [7:0]  rx_char = '0;
  logic        parity_err = 1'b0;
  logic        framing_err = 1'b0;
  logic        noise_err = 1'b0;
  logic        overrun_err = 1'b0;
  logic        read_counter = 1'b0;
  logic [5:0]  read_index = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  event_code;
  logic [6:0]  frame_length;
  logic        receiving;
  logic [31:0] read_data;

  // Mirror of the receiver state and its registers.
  hafr_pkg::phase_t rx_phase = hafr_pkg::PH_IDLE;
  bit          parity_pending = 1'b0;
  logic [7:0]  payload_mem [PAYLOAD_DEPTH];
  logic [6:0]  payload_len = '0;
  int          payload_hiwater = 0;
  logic [31:0] stat_cnt [hafr_pkg::NUM_CNT];
  logic [7:0]  cfg_flag = hafr_pkg::FLAG_RST;
  logic [7:0]  cfg_esc = hafr_pkg::ESC_RST;
  logic [7:0]  cfg_mask = hafr_pkg::MASK_RST;
  logic [6:0]  cfg_limit = hafr_pkg::LIMIT_RST;

  deframer_out_t deframer_outs [$];
  deframer_out_t want;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int busy_items = 0;
  int frames_done = 0;
  int error_events = 0;
  int config_sets = 0;
  int mismatches = 0;
  int stall_cycles = 0;

  function automatic logic [6:0] payload_cap();
    return (cfg_limit < 7'(PAYLOAD_DEPTH)) ? cfg_limit : 7'(PAYLOAD_DEPTH);
  endfunction

  function automatic logic [3:0] count_error(logic [2:0] idx, bit restart);
    stat_cnt[idx] = stat_cnt[idx] + 32'd1;
    if (restart) rx_phase = hafr_pkg::PH_WAIT;
    error_events++;
    return hafr_pkg::EV_PARITY + {1'b0, idx};
  endfunction

  function automatic logic [3:0] store_payload(logic [7:0] b);
    if (payload_len < payload_cap()) begin
      payload_mem[payload_len] = b;
      payload_len = payload_len + 7'd1;
      if (int'(payload_len) > payload_hiwater) payload_hiwater = int'(payload_len);
      return hafr_pkg::EV_STORED;
    end
    return count_error(hafr_pkg::CNT_OVERFLOW, 1'b1);
  endfunction

  // Advances the mirrored state by one request and returns the result it should give.
  function automatic deframer_out_t deframe(deframer_in_t it);
    deframer_out_t o;
    logic pe;
    logic [7:0] n;
    o.ev = hafr_pkg::EV_NONE;
    o.data = '0;
    pe = it.pe;
    if (!(it.func == FUNC_NOP ||
          (it.func == hafr_pkg::FUNC_CHAR && (!it.cv || rx_phase == hafr_pkg::PH_IDLE))))
      busy_items++;
    case (it.func)
      hafr_pkg::FUNC_CHAR: begin
        if (it.pe) parity_pending = 1'b1;
        if (it.cv && rx_phase != hafr_pkg::PH_IDLE) begin
          if (parity_pending) begin
            parity_pending = 1'b0;
            pe = 1'b1;
          end
          if (pe) o.ev = count_error(hafr_pkg::CNT_PARITY, 1'b1);
          else if (it.fe) o.ev = count_error(hafr_pkg::CNT_FRAMING, 1'b1);
          else if (it.ne) o.ev = count_error(hafr_pkg::CNT_NOISE, 1'b1);
          else if (it.oe) o.ev = count_error(hafr_pkg::CNT_OVERRUN, 1'b1);
          else begin
            case (rx_phase)
              hafr_pkg::PH_WAIT: begin
                if (it.ch == cfg_flag) begin
                  rx_phase = hafr_pkg::PH_DATA;
                  payload_len = '0;
                end else o.ev = count_error(hafr_pkg::CNT_NO_FLAG, 1'b0);
              end
              hafr_pkg::PH_DATA: begin
                if (it.ch == cfg_flag) begin
                  if (payload_len != 0) begin
                    rx_phase = hafr_pkg::PH_IDLE;
                    o.ev = hafr_pkg::EV_DONE;
                    frames_done++;
                  end else o.ev = count_error(hafr_pkg::CNT_EMPTY, 1'b0);
                end else if (it.ch == cfg_esc) rx_phase = hafr_pkg::PH_ESC;
                else o.ev = store_payload(it.ch);
              end
              default: begin
                n = it.ch ^ cfg_mask;
                if (payload_len >= payload_cap())
                  o.ev = count_error(hafr_pkg::CNT_OVERFLOW, 1'b1);
                else if (n == cfg_flag || n == cfg_esc) begin
                  rx_phase = hafr_pkg::PH_DATA;
                  o.ev = store_payload(n);
                end else o.ev = count_error(hafr_pkg::CNT_BAD_ESC, 1'b1);
              end
            endcase
          end
        end
      end
      hafr_pkg::FUNC_ARM: begin
        rx_phase = hafr_pkg::PH_WAIT;
        parity_pending = 1'b0;
      end
      hafr_pkg::FUNC_READ: begin
        if (it.rc) begin
          if (it.ri < 6'd8) o.data = stat_cnt[it.ri[2:0]];
        end else o.data = {24'd0, payload_mem[it.ri]};
      end
      default: ;
    endcase
    o.len = payload_len;
    o.rcv = (rx_phase != hafr_pkg::PH_IDLE);
    return o;
  endfunction

  function automatic deframer_in_t blank_req(logic [1:0] f);
    deframer_in_t it;
    it.func = f;
    it.cv = 1'($urandom);
    it.ch = 8'($urandom);
    it.pe = 1'($urandom);
    it.fe = 1'($urandom);
    it.ne = 1'($urandom);
    it.oe = 1'($urandom);
    it.rc = 1'($urandom);
    it.ri = 6'($urandom);
    return it;
  endfunction

  function automatic deframer_in_t line_req(logic [7:0] d, logic cv, logic pe, logic fe,
                                            logic ne, logic oe);
    deframer_in_t it;
    it = blank_req(hafr_pkg::FUNC_CHAR);
    it.cv = cv;
    it.ch = d;
    it.pe = pe;
    it.fe = fe;
    it.ne = ne;
    it.oe = oe;
    return it;
  endfunction

  function automatic deframer_in_t char_req(logic [7:0] d);
    return line_req(d, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
  endfunction

  // Payload reads only ever touch bytes that have been stored at least once.
  function automatic deframer_in_t read_req(logic rc, logic [5:0] ri);
    deframer_in_t it;
    it = blank_req(hafr_pkg::FUNC_READ);
    it.rc = rc;
    it.ri = ri;
    if (!rc && int'(ri) >= payload_hiwater) begin
      if (payload_hiwater == 0) it.rc = 1'b1;
      else it.ri = 6'($urandom_range(payload_hiwater - 1));
    end
    return it;
  endfunction

  function automatic deframer_in_t noise_req();
    deframer_in_t it;
    it = blank_req(2'($urandom));
    if (it.func == hafr_pkg::FUNC_READ) return read_req(it.rc, it.ri);
    it.cv = ($urandom_range(3) != 0);
    case ($urandom_range(5))
      0: it.ch = cfg_flag;
      1: it.ch = cfg_esc;
      default: ;
    endcase
    it.pe = ($urandom_range(7) == 0);
    it.fe = ($urandom_range(7) == 0);
    it.ne = ($urandom_range(7) == 0);
    it.oe = ($urandom_range(7) == 0);
    return it;
  endfunction

  task automatic push_request(deframer_in_t it);
    if (snd_idle_pct != 0 && $urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
    end
    in_valid <= 1'b1;
    func <= it.func;
    char_valid <= it.cv;
    rx_char <= it.ch;
    parity_err <= it.pe;
    framing_err <= it.fe;
    noise_err <= it.ne;
    overrun_err <= it.oe;
    read_counter <= it.rc;
    read_index <= it.ri;
    do @(posedge clk); while (!in_ready);
    deframer_outs.push_back(deframe(it));
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (deframer_outs.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      hafr_pkg::CFG_FLAG: cfg_flag = value;
      hafr_pkg::CFG_ESC: cfg_esc = value;
      hafr_pkg::CFG_MASK: cfg_mask = value;
      default: cfg_limit = value[6:0];
    endcase
  endtask

  task automatic set_config(logic [7:0] f, logic [7:0] e, logic [7:0] m, logic [6:0] l);
    write_reg(hafr_pkg::CFG_FLAG, f);
    write_reg(hafr_pkg::CFG_ESC, e);
    write_reg(hafr_pkg::CFG_MASK, m);
    write_reg(hafr_pkg::CFG_LIMIT, {1'b0, l});
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    config_sets++;
  endtask

  // One framed payload with stuffing; dirty frames get stray requests mixed in.
  task automatic send_frame(bit dirty);
    int len;
    int pick;
    int i;
    logic [7:0] b;
    pick = $urandom_range(99);
    if (pick < 3) len = 0;
    else if (pick < 7) len = int'(payload_cap());
    else if (pick < 11) len = int'(payload_cap()) + $urandom_range(1, 2);
    else if (pick < 18) len = $urandom_range(1, int'(payload_cap()));
    else len = $urandom_range(1, (payload_cap() < 10) ? int'(payload_cap()) : 10);
    if (rx_phase == hafr_pkg::PH_IDLE || $urandom_range(9) == 0)
      push_request(blank_req(hafr_pkg::FUNC_ARM));
    push_request(char_req(cfg_flag));
    for (i = 0; i < len; i++) begin
      case ($urandom_range(9))
        0: b = cfg_flag;
        1: b = cfg_esc;
        default: b = 8'($urandom);
      endcase
      if (dirty && $urandom_range(19) == 0) push_request(noise_req());
      // A plain byte sent escaped now and then is a bad escape.
      if (b == cfg_flag || b == cfg_esc || $urandom_range(15) == 0) begin
        push_request(char_req(cfg_esc));
        push_request(char_req(b ^ cfg_mask));
      end else push_request(char_req(b));
    end
    push_request(char_req(cfg_flag));
    if ($urandom_range(1)) begin
      push_request(read_req(1'b0, 6'($urandom)));
      push_request(read_req(1'b1, 6'($urandom_range(7))));
    end
  endtask

  task automatic test_framing_basics();
    deframer_in_t it;
    push_request(char_req(hafr_pkg::FLAG_RST));
    push_request(read_req(1'b1, 6'd63));
    push_request(blank_req(hafr_pkg::FUNC_ARM));
    push_request(char_req(8'h41));
    push_request(char_req(hafr_pkg::FLAG_RST));
    push_request(char_req(hafr_pkg::FLAG_RST));
    push_request(char_req(8'h00));
    push_request(char_req(8'hFF));
    push_request(char_req(hafr_pkg::FLAG_RST));
    push_request(read_req(1'b0, 6'd1));
    it = blank_req(FUNC_NOP);
    it.cv = 1'b1;
    it.ch = 8'hFF;
    it.pe = 1'b1;
    it.ri = 6'h3F;
    push_request(it);
  endtask

  task automatic test_escapes();
    push_request(blank_req(hafr_pkg::FUNC_ARM));
    push_request(char_req(hafr_pkg::FLAG_RST));
    push_request(char_req(hafr_pkg::ESC_RST));
    push_request(char_req(hafr_pkg::FLAG_RST ^ hafr_pkg::MASK_RST));
    push_request(char_req(hafr_pkg::ESC_RST));
    push_request(char_req(hafr_pkg::ESC_RST ^ hafr_pkg::MASK_RST));
    push_request(char_req(hafr_pkg::ESC_RST));
    push_request(char_req(8'h41));
  endtask

  task automatic test_line_errors();
    // Parity reported without a character waits for the next character.
    push_request(line_req(8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
    push_request(char_req(hafr_pkg::FLAG_RST));
    push_request(line_req(hafr_pkg::FLAG_RST, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0));
    push_request(line_req(hafr_pkg::FLAG_RST, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0));
    push_request(line_req(hafr_pkg::FLAG_RST, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1));
    push_request(line_req(hafr_pkg::FLAG_RST, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
    // Arming drops a pending parity error.
    push_request(line_req(8'hFF, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
    push_request(blank_req(hafr_pkg::FUNC_ARM));
    push_request(char_req(hafr_pkg::FLAG_RST));
  endtask

  task automatic test_overflow();
    push_request(blank_req(hafr_pkg::FUNC_ARM));
    push_request(char_req(cfg_flag));
    push_request(char_req(8'h33));
    push_request(char_req(8'h44));
    push_request(char_req(cfg_flag));
    push_request(char_req(8'h55));
    push_request(char_req(cfg_esc));
    push_request(char_req(cfg_flag ^ cfg_mask));
  endtask

  task automatic test_random_traffic(int count);
    int stop_at;
    int pick;
    stop_at = busy_items + count;
    while (busy_items < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 70) send_frame(pick < 20);
      else if (pick < 85) repeat ($urandom_range(1, 4)) push_request(noise_req());
      else push_request(read_req(1'($urandom), 6'($urandom)));
    end
  endtask

  task automatic test_drain_pause();
    send_frame(1'b0);
    wait_for_results();
    send_frame(1'b0);
  endtask

  hdlc_async_frame_receiver u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .func         (func),
    .char_valid   (char_valid),
    .rx_char      (rx_char),
    .parity_err   (parity_err),
    .framing_err  (framing_err),
    .noise_err    (noise_err),
    .overrun_err  (overrun_err),
    .read_counter (read_counter),
    .read_index   (read_index),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .event_code   (event_code),
    .frame_length (frame_length),
    .receiving    (receiving),
    .read_data    (read_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (deframer_outs.size() == 0) begin
        $error("result with no request outstanding: event_code %0d", event_code);
        mismatches++;
      end else begin
        want = deframer_outs.pop_front();
        if (event_code !== want.ev) begin
          $error("event_code: expected %0d, got %0d", want.ev, event_code);
          mismatches++;
        end
        if (frame_length !== want.len) begin
          $error("frame_length: expected %0d, got %0d", want.len, frame_length);
          mismatches++;
        end
        if (receiving !== want.rcv) begin
          $error("receiving: expected %0d, got %0d", want.rcv, receiving);
          mismatches++;
        end
        if (read_data !== want.data) begin
          $error("read_data: expected %0h, got %0h", want.data, read_data);
          mismatches++;
        end
      end
    end
    out_ready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin
    logic [7:0] f;
    logic [7:0] e;
    foreach (stat_cnt[i]) stat_cnt[i] = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    snd_idle_pct = 9;
    rcv_idle_pct = 81;
    test_framing_basics();
    test_escapes();
    test_line_errors();
    wait_for_results();
    set_config(8'h00, 8'hFF, 8'hFF, 7'd1);
    test_overflow();
    test_random_traffic(120);
    wait_for_results();
    set_config(hafr_pkg::FLAG_RST, hafr_pkg::ESC_RST, hafr_pkg::MASK_RST, 7'd64);
    test_random_traffic(210);
    wait_for_results();

    snd_idle_pct = 81;
    rcv_idle_pct = 9;
    set_config(8'hFF, 8'h00, 8'h00, 7'd5);
    test_random_traffic(120);
    test_drain_pause();
    test_random_traffic(120);
    wait_for_results();

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    f = 8'($urandom);
    do e = 8'($urandom); while (e == f);
    set_config(f, e, 8'($urandom), 7'($urandom_range(1, 64)));
    test_random_traffic(210);
    wait_for_results();
    set_config(e, f, 8'($urandom), 7'd64);
    test_random_traffic(170);
    wait_for_results();
    repeat (10) @(posedge clk);

    if (deframer_outs.size() != 0) begin
      $error("%0d results never arrived", deframer_outs.size());
      mismatches++;
    end
    $display("tb_top: %0d working requests across %0d register settings and three idle mixes",
             busy_items, config_sets + 1);
    $display("tb_top: %0d frames completed, %0d error events counted", frames_done,
             error_events);
    if (mismatches == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

endmodule

// File: hdlc_async_frame_receiver.f
+incdir+rtl/core
rtl/core/hafr_pkg.sv
rtl/core/hafr_ram.sv
rtl/core/hdlc_async_frame_receiver.sv
bench/tb_top.sv
